// ----- design/hcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the host command byte parser.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    // Command codes, taken when no gather is in progress
    localparam logic [7:0] CMD_STOP      = 8'h30;
    localparam logic [7:0] CMD_SEND      = 8'h31;
    localparam logic [7:0] CMD_READBACK  = 8'h32;
    localparam logic [7:0] CMD_PARAMS    = 8'h33;
    localparam logic [7:0] CMD_SAVE      = 8'h34;
    localparam logic [7:0] CMD_LOG       = 8'h35;
    localparam logic [7:0] CMD_BLK_CLR   = 8'h36;
    localparam logic [7:0] CMD_BLK_DOWN  = 8'h37;
    localparam logic [7:0] CMD_BLK_UP    = 8'h38;
    localparam logic [7:0] CMD_BLK_SET   = 8'h39;

    localparam logic [7:0] TRAILER       = 8'hAB;

    localparam int FRAME_LEN   = 56;
    localparam int FRAME_WORDS = FRAME_LEN / 4;
    localparam int CNT_W       = 6;
    localparam int ROW_W       = 4;

    // Result kinds
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_READBACK   = 3'd1;
    localparam logic [2:0] EV_SAVE       = 3'd2;
    localparam logic [2:0] EV_CARD_SEND  = 3'd3;
    localparam logic [2:0] EV_WORD       = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic             take_byte;
        logic             rd_en;
        logic [ROW_W-1:0] word_idx;
        logic             load_word;
        logic             load_final;
    } hcbp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic frame_good;
    } hcbp_sts_t;

    // Architectural flags shown with every result
    typedef struct packed {
        logic        beeper;
        logic [15:0] card_block;
        logic        log_info_flag;
        logic        log_enable;
        logic        send_flag;
        logic        stop_flag;
    } hcbp_flags_t;

endpackage

// ----- design/hcbp_ctrl.sv -----
// ----------------------------------------------------------------------------
// hcbp_ctrl
// Sequencer: takes bytes and, after a good frame, walks the parameter words.
// ----------------------------------------------------------------------------
module hcbp_ctrl #(
    parameter int PARAM_COUNT = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hcbp_pkg::hcbp_sts_t   sts,
    output hcbp_pkg::hcbp_cmd_t   cmd
);
    import hcbp_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_SEND  = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    localparam logic [ROW_W-1:0] LAST_IDX = ROW_W'(PARAM_COUNT - 1);

    logic [1:0]       state_reg, state_next;
    logic [ROW_W-1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.word_idx   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = sts.out_free;
                cmd.take_byte = in_valid && sts.out_free;
                if (cmd.take_byte && sts.frame_good)
                begin
                    idx_next   = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (sts.out_free)
                begin
                    cmd.load_word = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FINAL:
            begin
                if (sts.out_free)
                begin
                    cmd.load_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- design/hcbp_dp.sv -----
// ----------------------------------------------------------------------------
// hcbp_dp
// Datapath: command decode, host flags, frame memory and result register.
// ----------------------------------------------------------------------------
module hcbp_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             rx_byte,
    input  logic                   card_ready,
    input  logic                   out_ready,
    input  hcbp_pkg::hcbp_cmd_t    cmd,
    output hcbp_pkg::hcbp_sts_t    sts,
    output logic                   out_valid,
    output logic [2:0]             event_res,
    output logic [3:0]             param_slot,
    output logic [31:0]            param_word,
    output logic                   last,
    output hcbp_pkg::hcbp_flags_t  flags
);
    import hcbp_pkg::*;

    // Gather and host state
    logic             gath_par_reg, gath_par_next;
    logic             gath_blk_reg, gath_blk_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [23:0]      asm_reg;
    hcbp_flags_t      flags_reg, flags_next;

    // Frame memory, one 32-bit word per row
    logic [31:0]      frame_mem [FRAME_WORDS];
    logic             mem_we;
    logic [ROW_W-1:0] rd_addr;
    logic [31:0]      rd_data_reg;
    logic             rd_zero_reg;

    // Result register
    logic             out_valid_reg;
    logic [2:0]       ev_reg;
    logic [3:0]       slot_reg;
    logic [31:0]      word_reg;
    logic             last_reg;

    logic [2:0]       ev_byte;
    logic             frame_good;
    logic             out_free;

    assign frame_good = gath_par_reg && (count_reg == CNT_W'(FRAME_LEN)) && (rx_byte == TRAILER);
    assign out_free   = !out_valid_reg || out_ready;
    assign sts.out_free   = out_free;
    assign sts.frame_good = frame_good;

    always_comb
    begin
        gath_par_next = gath_par_reg;
        gath_blk_next = gath_blk_reg;
        count_next    = count_reg;
        flags_next    = flags_reg;
        ev_byte       = EV_NONE;
        mem_we        = 1'b0;
        if (cmd.take_byte)
        begin
            if (gath_par_reg)
            begin
                if (count_reg < CNT_W'(FRAME_LEN))
                begin
                    mem_we     = (count_reg[1:0] == 2'd3);
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    count_next    = '0;
                    gath_par_next = 1'b0;
                end
            end
            else if (gath_blk_reg)
            begin
                if (count_reg == '0)
                begin
                    count_next = CNT_W'(1);
                end
                else
                begin
                    flags_next.card_block = {rx_byte, asm_reg[23:16]};
                    ev_byte               = EV_CARD_SEND;
                    count_next            = '0;
                    gath_blk_next         = 1'b0;
                end
            end
            else
            begin
                flags_next.beeper = 1'b1;
                case (rx_byte)
                    CMD_STOP:     flags_next.stop_flag = !flags_reg.stop_flag;
                    CMD_SEND:     flags_next.send_flag = !flags_reg.send_flag;
                    CMD_READBACK: ev_byte = EV_READBACK;
                    CMD_PARAMS:
                    begin
                        gath_par_next = 1'b1;
                        count_next    = '0;
                    end
                    CMD_SAVE:     ev_byte = EV_SAVE;
                    CMD_LOG:
                    begin
                        if (!flags_reg.log_enable)
                        begin
                            flags_next.log_enable    = 1'b1;
                            flags_next.card_block    = '0;
                            flags_next.log_info_flag = 1'b0;
                        end
                        else
                        begin
                            flags_next.log_enable    = 1'b0;
                            flags_next.log_info_flag = 1'b1;
                        end
                    end
                    CMD_BLK_CLR:
                    begin
                        flags_next.card_block = '0;
                        ev_byte               = EV_CARD_SEND;
                    end
                    CMD_BLK_DOWN:
                    begin
                        if (card_ready)
                        begin
                            flags_next.card_block = flags_reg.card_block - 1'b1;
                            ev_byte               = EV_CARD_SEND;
                        end
                        flags_next.beeper = 1'b0;
                    end
                    CMD_BLK_UP:
                    begin
                        if (card_ready)
                        begin
                            flags_next.card_block = flags_reg.card_block + 1'b1;
                            ev_byte               = EV_CARD_SEND;
                        end
                        flags_next.beeper = 1'b0;
                    end
                    CMD_BLK_SET:
                    begin
                        gath_blk_next = 1'b1;
                        count_next    = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gath_par_reg <= 1'b0;
            gath_blk_reg <= 1'b0;
            count_reg    <= '0;
            flags_reg    <= '0;
        end
        else
        begin
            gath_par_reg <= gath_par_next;
            gath_blk_reg <= gath_blk_next;
            count_reg    <= count_next;
            flags_reg    <= flags_next;
        end
    end

    // Hold the last three bytes taken for word and block assembly
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte)
        begin
            asm_reg <= {rx_byte, asm_reg[23:8]};
        end
    end

    // Rows past the frame read as zero
    assign rd_addr = (cmd.word_idx < ROW_W'(FRAME_WORDS)) ? cmd.word_idx : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[count_reg[CNT_W-1:2]] <= {rx_byte, asm_reg};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= frame_mem[rd_addr];
            rd_zero_reg <= (cmd.word_idx >= ROW_W'(FRAME_WORDS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_word || cmd.load_final || (cmd.take_byte && !frame_good))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            ev_reg   <= EV_WORD;
            slot_reg <= cmd.word_idx;
            word_reg <= rd_zero_reg ? 32'd0 : rd_data_reg;
            last_reg <= 1'b0;
        end
        else if (cmd.load_final)
        begin
            ev_reg   <= EV_READBACK;
            slot_reg <= '0;
            word_reg <= '0;
            last_reg <= 1'b1;
        end
        else if (cmd.take_byte && !frame_good)
        begin
            ev_reg   <= ev_byte;
            slot_reg <= '0;
            word_reg <= '0;
            last_reg <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_res  = ev_reg;
    assign param_slot = slot_reg;
    assign param_word = word_reg;
    assign last       = last_reg;
    assign flags      = flags_reg;

endmodule

// ----- design/host_command_byte_parser.sv -----
// ----------------------------------------------------------------------------
// host_command_byte_parser
// Host debugger byte parser: command decode, parameter frame and block index.
// ----------------------------------------------------------------------------
// Output: a byte's result beat is registered and appears in the cycle after
//   the byte is accepted. Throughput: one byte per cycle while the result
//   register is free; a good trailer holds the input while the frame memory
//   is read row by row (read, then load the result) plus the readback beat.
// Reset: rst_n clears all flags, the block index and the gather state; the
//   frame memory is not cleared and is always fully written before a read.
// ----------------------------------------------------------------------------
module host_command_byte_parser #(
    parameter int PARAM_COUNT = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: [7:0] rx_byte, [8] card_ready, rest zero
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // tdata: [3:0] param_slot, [35:4] param_word, [36] stop_flag,
    //        [37] send_flag, [38] log_enable, [39] log_info_flag,
    //        [55:40] card_block, [56] beeper, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,
    // tuser: [2:0] event_res
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import hcbp_pkg::*;

    hcbp_cmd_t   cmd;
    hcbp_sts_t   sts;
    hcbp_flags_t flags;
    logic [3:0]  param_slot;
    logic [31:0] param_word;

    // Sequencer: take bytes while idle, walk the words after a good frame
    hcbp_ctrl #(
        .PARAM_COUNT (PARAM_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: decode, flags, frame memory and the result register
    hcbp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (s_axis_tdata[7:0]),
        .card_ready (s_axis_tdata[8]),
        .out_ready  (m_axis_tready),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_axis_tvalid),
        .event_res  (m_axis_tuser),
        .param_slot (param_slot),
        .param_word (param_word),
        .last       (m_axis_tlast),
        .flags      (flags)
    );

    // Flags come live from the state registers: no byte is taken while a
    // result beat is pending, so they always match the beat on the bus.
    assign m_axis_tdata = {7'd0, flags.beeper, flags.card_block, flags.log_info_flag,
                           flags.log_enable, flags.send_flag, flags.stop_flag,
                           param_word, param_slot};

    // A parameter word beat never closes the byte's results
    a_word_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == EV_WORD)) |-> !m_axis_tlast)
        else $error("parameter word beat marked last");

    // A good trailer blocks input on the next cycle while words stream out
    a_frame_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_byte && sts.frame_good) |=> !s_axis_tready)
        else $error("input taken during frame readout");

    // Word slots stay within the configured count
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == EV_WORD)) |->
        (32'(param_slot) < PARAM_COUNT))
        else $error("parameter slot out of range");

    // Never load a byte result and a frame result in the same cycle
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.take_byte && (cmd.load_word || cmd.load_final)))
        else $error("conflicting result loads");

endmodule

// ----- test/tb_host_command_byte_parser.sv -----
// ----------------------------------------------------------------------------
// tb_host_command_byte_parser
// Self-checking bench: drives host bytes into the parser, predicts each
// result beat (events, parameter words, flag state) and checks it in order.
// ----------------------------------------------------------------------------
module tb_host_command_byte_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import hcbp_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int PARAM_COUNT    = 14;
    localparam int TIMEOUT_CYCLES = 500_000;
    localparam int TAIL_CYCLES    = 20;

    // One expected result beat
    typedef struct {
        logic [2:0]  ev;
        logic [3:0]  slot;
        logic [31:0] word;
        logic        last;
        hcbp_flags_t flags;
    } parser_beat_t;

    // Tracks the parser state, builds the beats each accepted byte must give,
    // and checks the beats leaving the block against them, oldest first.
    class param_frame_scoreboard;
        parser_beat_t beats_due[$];
        int           n_errors;
        int           n_checked;
        logic         in_frame;
        logic         in_block;
        int           frame_fill;
        logic [7:0]   frame_bytes[FRAME_LEN];
        hcbp_flags_t  flags;

        function new();
            n_errors   = 0;
            n_checked  = 0;
            in_frame   = 1'b0;
            in_block   = 1'b0;
            frame_fill = 0;
            flags      = '0;
            foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
        endfunction

        function void queue_beat(logic [2:0] ev, logic [3:0] slot, logic [31:0] word,
                                 logic last);
            parser_beat_t b;
            b.ev    = ev;
            b.slot  = slot;
            b.word  = word;
            b.last  = last;
            b.flags = flags;
            beats_due.push_back(b);
        endfunction

        // Advance the state by one accepted byte and queue its beats
        function void take_byte(logic [7:0] rx, logic ready);
            logic [2:0]  ev;
            logic [31:0] w;
            ev = EV_NONE;
            if (in_frame) begin
                if (frame_fill < FRAME_LEN) begin
                    frame_bytes[frame_fill] = rx;
                    frame_fill++;
                end else begin
                    frame_fill = 0;
                    in_frame   = 1'b0;
                    if (rx == TRAILER) begin
                        for (int i = 0; i < PARAM_COUNT; i++) begin
                            w = '0;
                            for (int k = 0; k < 4; k++)
                                if (4 * i + k < FRAME_LEN)
                                    w[8 * k +: 8] = frame_bytes[4 * i + k];
                            queue_beat(EV_WORD, 4'(i), w, 1'b0);
                        end
                        queue_beat(EV_READBACK, 4'd0, 32'd0, 1'b1);
                        return;
                    end
                end
            end else if (in_block) begin
                if (frame_fill < 1) begin
                    frame_bytes[0] = rx;
                    frame_fill     = 1;
                end else begin
                    flags.card_block = {rx, frame_bytes[0]};
                    ev               = EV_CARD_SEND;
                    frame_fill       = 0;
                    in_block         = 1'b0;
                end
            end else begin
                flags.beeper = 1'b1;
                case (rx)
                    CMD_STOP:     flags.stop_flag = ~flags.stop_flag;
                    CMD_SEND:     flags.send_flag = ~flags.send_flag;
                    CMD_READBACK: ev = EV_READBACK;
                    CMD_PARAMS:
                    begin
                        in_frame   = 1'b1;
                        frame_fill = 0;
                    end
                    CMD_SAVE:     ev = EV_SAVE;
                    CMD_LOG:
                    begin
                        if (!flags.log_enable) begin
                            flags.log_enable    = 1'b1;
                            flags.card_block    = '0;
                            flags.log_info_flag = 1'b0;
                        end else begin
                            flags.log_info_flag = 1'b1;
                            flags.log_enable    = 1'b0;
                        end
                    end
                    CMD_BLK_CLR:
                    begin
                        flags.card_block = '0;
                        ev               = EV_CARD_SEND;
                    end
                    CMD_BLK_DOWN:
                    begin
                        if (ready) begin
                            flags.card_block = flags.card_block - 16'd1;
                            ev               = EV_CARD_SEND;
                        end
                        flags.beeper = 1'b0;
                    end
                    CMD_BLK_UP:
                    begin
                        if (ready) begin
                            flags.card_block = flags.card_block + 16'd1;
                            ev               = EV_CARD_SEND;
                        end
                        flags.beeper = 1'b0;
                    end
                    CMD_BLK_SET:
                    begin
                        in_block   = 1'b1;
                        frame_fill = 0;
                    end
                    default: ;
                endcase
            end
            queue_beat(ev, 4'd0, 32'd0, 1'b1);
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            $display("[%0t] beat %0d: %s is %0h, want %0h", $realtime, n_checked, field,
                     got, want);
            n_errors++;
        endtask

        // Compare one accepted output beat with the oldest expected beat
        task check_beat(logic [2:0] tuser, logic [63:0] tdata, logic tlast);
            parser_beat_t want;
            hcbp_flags_t  got_flags;
            if (beats_due.size() == 0) begin
                report("unexpected beat", {61'd0, tuser}, 64'd0);
                n_checked++;
                return;
            end
            want      = beats_due.pop_front();
            got_flags = tdata[56:36];
            if (tuser !== want.ev) report("event_res", tuser, want.ev);
            if (tdata[3:0] !== want.slot) report("param_slot", tdata[3:0], want.slot);
            if (tdata[35:4] !== want.word) report("param_word", tdata[35:4], want.word);
            if (tlast !== want.last) report("last", tlast, want.last);
            if (got_flags.stop_flag !== want.flags.stop_flag)
                report("stop_flag", got_flags.stop_flag, want.flags.stop_flag);
            if (got_flags.send_flag !== want.flags.send_flag)
                report("send_flag", got_flags.send_flag, want.flags.send_flag);
            if (got_flags.log_enable !== want.flags.log_enable)
                report("log_enable", got_flags.log_enable, want.flags.log_enable);
            if (got_flags.log_info_flag !== want.flags.log_info_flag)
                report("log_info_flag", got_flags.log_info_flag, want.flags.log_info_flag);
            if (got_flags.card_block !== want.flags.card_block)
                report("card_block", got_flags.card_block, want.flags.card_block);
            if (got_flags.beeper !== want.flags.beeper)
                report("beeper", got_flags.beeper, want.flags.beeper);
            if (tdata[63:57] !== 7'd0) report("tdata padding", tdata[63:57], 64'd0);
            n_checked++;
        endtask
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Idle odds in percent, changed between phases
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int n_sent         = 0;

    param_frame_scoreboard sb = new();

    host_command_byte_parser #(
        .PARAM_COUNT(PARAM_COUNT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: check the beat taken at this edge, then pick the next ready.
    // Sampling right after the edge sees the values the flops clocked on.
    initial
    begin
        forever begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_beat(m_axis_tuser, m_axis_tdata, m_axis_tlast);
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Send one byte and hold it until the block takes it. Valid stays high
    // across back-to-back beats and drops only for an idle cycle or a drain.
    task automatic send_byte(input logic [7:0] rx, input logic ready);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, ready, rx};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.take_byte(rx, ready);
        n_sent++;
    endtask

    // Drop valid and hold off until every expected beat has come out
    task automatic drain_results();
        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;
        while (sb.beats_due.size() != 0) @(posedge clk);
    endtask

    // Content byte: often a command code, to make sure gathered bytes are
    // not decoded as commands
    function automatic logic [7:0] payload_byte();
        if ($urandom_range(3) == 0) return CMD_STOP + 8'($urandom_range(9));
        return 8'($urandom_range(255));
    endfunction

    // Parameter frame: command, 56 content bytes, trailer. With extremes set,
    // the words alternate all-zero and all-one bytes with a lone top bit.
    task automatic send_frame(input logic [7:0] trailer, input bit extremes);
        logic [7:0] b;
        send_byte(CMD_PARAMS, 1'($urandom_range(1)));
        for (int i = 0; i < FRAME_LEN; i++) begin
            if (extremes) b = ((i / 4) % 2 == 1) ? 8'hFF : ((i % 4 == 3) ? 8'h80 : 8'h00);
            else          b = payload_byte();
            send_byte(b, 1'($urandom_range(1)));
        end
        send_byte(trailer, 1'($urandom_range(1)));
    endtask

    task automatic send_block_set(input logic [7:0] lo, input logic [7:0] hi);
        send_byte(CMD_BLK_SET, 1'($urandom_range(1)));
        send_byte(lo, 1'($urandom_range(1)));
        send_byte(hi, 1'($urandom_range(1)));
    endtask

    // Mostly well-formed sequences with random content, some loose bytes
    task automatic run_random(input int n_items);
        int         start;
        int         pick;
        logic [7:0] t;
        start = n_sent;
        while (n_sent - start < n_items) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                t = TRAILER;
                if ($urandom_range(9) == 0)
                    do t = 8'($urandom_range(255)); while (t == TRAILER);
                send_frame(t, 1'b0);
            end else if (pick < 25) begin
                send_block_set(payload_byte(), payload_byte());
            end else if (pick < 85) begin
                send_byte(CMD_STOP + 8'($urandom_range(9)), 1'($urandom_range(1)));
            end else begin
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            // Now and then let the output run dry before going on
            if ($urandom_range(39) == 0) drain_results();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every command, both toggles, wrap in both directions,
        // steps with the card not ready, unknown codes, block set extremes
        send_byte(CMD_STOP, 1'b0);
        send_byte(CMD_STOP, 1'b1);
        send_byte(CMD_SEND, 1'b0);
        send_byte(CMD_SEND, 1'b1);
        send_byte(CMD_READBACK, 1'b0);
        send_byte(CMD_SAVE, 1'b1);
        send_byte(CMD_LOG, 1'b0);
        send_byte(CMD_LOG, 1'b1);
        send_byte(CMD_BLK_CLR, 1'b0);
        send_byte(CMD_BLK_DOWN, 1'b1);
        send_byte(CMD_BLK_UP, 1'b1);
        send_byte(CMD_BLK_DOWN, 1'b0);
        send_byte(CMD_BLK_UP, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(TRAILER, 1'b1);
        send_block_set(8'hFF, 8'hFF);
        send_byte(CMD_BLK_UP, 1'b1);
        send_block_set(8'h00, 8'h80);
        send_byte(CMD_LOG, 1'b1);

        // Good frame with extreme words, then one with a bad trailer
        send_frame(TRAILER, 1'b1);
        send_frame(TRAILER ^ 8'h01, 1'b0);
        drain_results();

        // Random phases: no idling, slow sender, slow receiver, both
        src_idle_pct = 0;  sink_stall_pct = 0;
        run_random(60);
        drain_results();
        src_idle_pct = 88; sink_stall_pct = 0;
        run_random(60);
        drain_results();
        src_idle_pct = 0;  sink_stall_pct = 88;
        run_random(60);
        drain_results();
        src_idle_pct = 37; sink_stall_pct = 37;
        run_random(70);
        drain_results();

        // Let any stray beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.n_errors == 0 && sb.beats_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
